>>> rtl/bmrs_pkg.sv
// Shared types, constants and helper functions for the bitmap row segmenter.
package bmrs_pkg;

    // Build limits
    localparam int MAX_SEGS  = 2;
    localparam int MAX_WIDTH = 32;
    localparam int ROW_W     = 32;
    localparam int COL_W     = 6;
    localparam int CNT_W     = 2;

    // Column count after reset
    localparam logic [COL_W-1:0] WIDTH_RESET = COL_W'(MAX_WIDTH);
    localparam logic [COL_W-1:0] WIDTH_MAX   = COL_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] CNT_SAT     = {CNT_W{1'b1}};

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One result item
    typedef struct packed {
        col_t seg0_left;
        col_t seg0_right;
        col_t seg1_left;
        col_t seg1_right;
        cnt_t run_count;
        logic too_curvy;
        logic row_done;
    } seg_result_t;

    // Bit x set for every column x below n
    function automatic row_t below_mask(input col_t n);
        row_t m;
        for (int x = 0; x < ROW_W; x++)
        begin
            m[x] = (COL_W'(x) < n);
        end
        return m;
    endfunction

    // Index of the lowest set bit, ROW_W when the vector is clear
    function automatic col_t first_set(input row_t v);
        col_t idx;
        idx = COL_W'(ROW_W);
        for (int x = ROW_W - 1; x >= 0; x--)
        begin
            if (v[x])
            begin
                idx = COL_W'(x);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/bmrs_if.sv
// Valid/ready channel interfaces for row items in and segment items out.
interface bmrs_in_if;
    logic           valid;
    logic           ready;
    bmrs_pkg::row_t row_bits;
    logic           last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface bmrs_out_if;
    logic           valid;
    logic           ready;
    bmrs_pkg::col_t seg0_left;
    bmrs_pkg::col_t seg0_right;
    bmrs_pkg::col_t seg1_left;
    bmrs_pkg::col_t seg1_right;
    bmrs_pkg::cnt_t run_count;
    logic           too_curvy;
    logic           row_done;

    modport source (
        output valid, output seg0_left, output seg0_right, output seg1_left,
        output seg1_right, output run_count, output too_curvy, output row_done,
        input ready
    );
    modport sink (
        input valid, input seg0_left, input seg0_right, input seg1_left,
        input seg1_right, input run_count, input too_curvy, input row_done,
        output ready
    );
endinterface

>>> rtl/bmrs_run_find.sv
// Finds the lowest run of set pixels in a row and strips it off.
module bmrs_run_find (
    input  bmrs_pkg::row_t rem,
    output logic           found,
    output bmrs_pkg::col_t left,
    output bmrs_pkg::col_t right,
    output bmrs_pkg::row_t rest
);
    import bmrs_pkg::*;

    // Start of run is the lowest set bit; end is the first clear bit above it
    always_comb
    begin
        found = |rem;
        left  = first_set(rem);
        right = first_set(~(rem | below_mask(left)));
        rest  = rem & ~below_mask(right);
    end

endmodule

>>> rtl/bmrs_row_core.sv
// Combinational row segmenter: width masking, chained run finders, slot fill.
module bmrs_row_core (
    input  bmrs_pkg::row_t        row_bits,
    input  logic                  last_row,
    input  bmrs_pkg::col_t        glyph_width,
    output bmrs_pkg::seg_result_t res
);
    import bmrs_pkg::*;

    localparam int S1 = (MAX_SEGS > 1) ? 1 : 0;

    col_t                           width;
    col_t                           half;
    logic [MAX_SEGS:0][ROW_W-1:0]   rem;
    logic [MAX_SEGS-1:0]            found;
    col_t [MAX_SEGS-1:0]            lefts;
    col_t [MAX_SEGS-1:0]            rights;
    col_t [MAX_SEGS-1:0]            slot_l;
    col_t [MAX_SEGS-1:0]            slot_r;
    logic [2:0]                     cnt;

    // Clamp width and drop columns past it
    always_comb
    begin
        width  = (glyph_width > WIDTH_MAX) ? WIDTH_MAX : glyph_width;
        half   = width >> 1;
        rem[0] = row_bits & below_mask(width);
    end

    // One finder per allowed run, each working on what the last one left
    for (genvar k = 0; k < MAX_SEGS; k++)
    begin : g_run
        bmrs_run_find u_find (
            .rem   (rem[k]),
            .found (found[k]),
            .left  (lefts[k]),
            .right (rights[k]),
            .rest  (rem[k+1])
        );

        // Empty slot repeats the previous one; blank row gives half width
        if (k == 0)
        begin : g_first
            assign slot_l[k] = found[k] ? lefts[k]  : half;
            assign slot_r[k] = found[k] ? rights[k] : half;
        end
        else
        begin : g_next
            assign slot_l[k] = found[k] ? lefts[k]  : slot_l[k-1];
            assign slot_r[k] = found[k] ? rights[k] : slot_r[k-1];
        end
    end

    // Run count, saturating
    always_comb
    begin
        cnt = '0;
        for (int k = 0; k < MAX_SEGS; k++)
        begin
            cnt = cnt + 3'(found[k]);
        end
    end

    // Result item
    always_comb
    begin
        res.seg0_left  = slot_l[0];
        res.seg0_right = slot_r[0];
        res.seg1_left  = slot_l[S1];
        res.seg1_right = slot_r[S1];
        res.run_count  = (cnt > 3'(CNT_SAT)) ? CNT_SAT : cnt[CNT_W-1:0];
        res.too_curvy  = |rem[MAX_SEGS];
        res.row_done   = last_row;
    end

endmodule

>>> rtl/bitmap_row_to_segments.sv
// Bitmap row segmenter top level: input register, segment logic, result register.
// Path: a row accepted into the input register has its result item loaded into the
// result register, which drives seg_out, as soon as that register is free.
// Throughput: one item per cycle when seg_out is ready; the input and result
// registers each advance whenever the stage after them is empty or being drained.
// Reset: both stages empty, glyph_width back to 32.
module bitmap_row_to_segments (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  bmrs_pkg::col_t       cfg_wr_data,
    bmrs_in_if.sink              row_in,
    bmrs_out_if.source           seg_out
);
    import bmrs_pkg::*;

    col_t        gw_reg;
    logic        s1_valid_reg;
    row_t        s1_row_reg;
    logic        s1_last_reg;
    logic        out_valid_reg;
    seg_result_t out_res_reg;
    seg_result_t core_res;
    logic        out_load;
    logic        s1_load;

    // Stage handshakes
    assign out_load     = !out_valid_reg || seg_out.ready;
    assign s1_load      = !s1_valid_reg || out_load;
    assign row_in.ready = s1_load;

    // Width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            gw_reg <= cfg_wr_data;
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= row_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && row_in.valid)
        begin
            s1_row_reg  <= row_in.row_bits;
            s1_last_reg <= row_in.last_row;
        end
    end

    bmrs_row_core u_core (
        .row_bits    (s1_row_reg),
        .last_row    (s1_last_reg),
        .glyph_width (gw_reg),
        .res         (core_res)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_res_reg <= core_res;
        end
    end

    // Output item
    assign seg_out.valid      = out_valid_reg;
    assign seg_out.seg0_left  = out_res_reg.seg0_left;
    assign seg_out.seg0_right = out_res_reg.seg0_right;
    assign seg_out.seg1_left  = out_res_reg.seg1_left;
    assign seg_out.seg1_right = out_res_reg.seg1_right;
    assign seg_out.run_count  = out_res_reg.run_count;
    assign seg_out.too_curvy  = out_res_reg.too_curvy;
    assign seg_out.row_done   = out_res_reg.row_done;

endmodule
